FILE: design/rcac_pkg.sv
// Shared types and constants for the RGB color adjustment chain.
// Used by every module of the block; depends on nothing else.
package rcac_pkg;

   localparam int unsigned NUM_STAGES = 8;

   localparam int unsigned ST_EXPOSURE  = 0;
   localparam int unsigned ST_CONTRAST  = 1;
   localparam int unsigned ST_BRIGHT    = 2;
   localparam int unsigned ST_LUMA      = 3;
   localparam int unsigned ST_SAT_MUL   = 4;
   localparam int unsigned ST_SAT_CLAMP = 5;
   localparam int unsigned ST_TEMP_MUL  = 6;
   localparam int unsigned ST_OUTPUT    = 7;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPOSURE_GAIN     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONTRAST_GAIN     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BRIGHTNESS_OFFSET = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SATURATION_GAIN   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TEMPERATURE_SHIFT = 3'd4;

   localparam logic [15:0]        EXPOSURE_GAIN_RESET     = 16'd4096;
   localparam logic [15:0]        CONTRAST_GAIN_RESET     = 16'd256;
   localparam logic signed [8:0]  BRIGHTNESS_OFFSET_RESET = 9'sd0;
   localparam logic signed [15:0] SATURATION_GAIN_RESET   = 16'sd4096;
   localparam logic signed [15:0] TEMPERATURE_SHIFT_RESET = 16'sd0;

   // Rec.601 luma weights in Q0.16; they sum to one.
   localparam logic [23:0] LUMA_WEIGHT_RED   = 24'd19595;
   localparam logic [23:0] LUMA_WEIGHT_GREEN = 24'd38470;
   localparam logic [23:0] LUMA_WEIGHT_BLUE  = 24'd7471;

   localparam logic [7:0] PIXEL_MAX = 8'hFF;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } req_data_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
   } rsp_data_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] advance;
   } stage_ctl_type;

endpackage

FILE: design/rcac_tone.sv
// One color channel through exposure, contrast and brightness, three register stages.
// Depends on rcac_pkg for the stage numbering and the stage control struct.
module rcac_tone (
   input  logic                  clock,
   input  rcac_pkg::stage_ctl_type ctl,
   input  logic [7:0]            chan_in,
   input  logic [15:0]           exposure_gain,
   input  logic [15:0]           contrast_gain,
   input  logic signed [8:0]     brightness_offset,
   output logic [7:0]            chan_out
);
   import rcac_pkg::*;

   logic [23:0]        exp_prod_ff, exp_prod_in;
   logic [7:0]         exp_val;
   logic signed [8:0]  ctr_diff;
   logic signed [25:0] ctr_sum_ff, ctr_sum_in;
   logic [16:0]        ctr_q;
   logic [7:0]         ctr_val;
   logic signed [9:0]  bri_sum;
   logic [7:0]         chan_ff, chan_in_next;

   always_comb begin
      exp_prod_in = 24'(chan_in) * 24'(exposure_gain);
      exp_val = (exp_prod_ff[23:20] != 4'd0) ? PIXEL_MAX : exp_prod_ff[19:12];

      ctr_diff = $signed({1'b0, exp_val}) - 9'sd128;
      ctr_sum_in = 26'(ctr_diff) * 26'($signed({1'b0, contrast_gain})) + 26'sd32768;

      ctr_q = ctr_sum_ff[24:8];
      if (ctr_sum_ff[25]) begin
         ctr_val = 8'd0;
      end else if (ctr_q > 17'd255) begin
         ctr_val = PIXEL_MAX;
      end else begin
         ctr_val = ctr_q[7:0];
      end

      bri_sum = $signed({2'b00, ctr_val}) + 10'(brightness_offset);
      if (bri_sum[9]) begin
         chan_in_next = 8'd0;
      end else if (bri_sum[8]) begin
         chan_in_next = PIXEL_MAX;
      end else begin
         chan_in_next = bri_sum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance[ST_EXPOSURE]) begin
         exp_prod_ff <= exp_prod_in;
      end
      if (ctl.advance[ST_CONTRAST]) begin
         ctr_sum_ff <= ctr_sum_in;
      end
      if (ctl.advance[ST_BRIGHT]) begin
         chan_ff <= chan_in_next;
      end
   end

   assign chan_out = chan_ff;

endmodule

FILE: design/rcac_sat.sv
// Luma and saturation mix for all three channels, three register stages.
// Depends on rcac_pkg for luma weights, stage numbering and the stage control struct.
module rcac_sat (
   input  logic                    clock,
   input  rcac_pkg::stage_ctl_type ctl,
   input  logic [2:0][7:0]         chan_in,
   input  logic signed [15:0]      saturation_gain,
   output logic [2:0][7:0]         chan_out
);
   import rcac_pkg::*;

   logic [23:0]        luma_ff, luma_in;
   logic [2:0][7:0]    chan_a_ff;
   logic [23:0]        luma_b_ff;
   logic signed [25:0] diff [3];
   logic signed [41:0] prod_ff [3];
   logic signed [41:0] prod_in [3];
   logic signed [42:0] mix [3];
   logic [2:0][7:0]    chan_ff, chan_in_next;

   always_comb begin
      luma_in = 24'(chan_in[0]) * LUMA_WEIGHT_RED
              + 24'(chan_in[1]) * LUMA_WEIGHT_GREEN
              + 24'(chan_in[2]) * LUMA_WEIGHT_BLUE;
      for (int i = 0; i < 3; i++) begin
         diff[i] = $signed({2'b00, chan_a_ff[i], 16'h0000}) - $signed({2'b00, luma_ff});
         prod_in[i] = 42'(diff[i]) * 42'(saturation_gain);
         mix[i] = $signed({7'd0, luma_b_ff, 12'h000}) + 43'(prod_ff[i]);
         if (mix[i][42]) begin
            chan_in_next[i] = 8'd0;
         end else if (mix[i][41:36] != 6'd0) begin
            chan_in_next[i] = PIXEL_MAX;
         end else begin
            chan_in_next[i] = mix[i][35:28];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance[ST_LUMA]) begin
         luma_ff   <= luma_in;
         chan_a_ff <= chan_in;
      end
      if (ctl.advance[ST_SAT_MUL]) begin
         luma_b_ff <= luma_ff;
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= prod_in[i];
         end
      end
      if (ctl.advance[ST_SAT_CLAMP]) begin
         chan_ff <= chan_in_next;
      end
   end

   assign chan_out = chan_ff;

endmodule

FILE: design/rgb_color_adjust_chain.sv
// Top level of the RGB color adjustment chain: registers, stage control, temperature, output.
// Depends on rcac_pkg, rcac_tone and rcac_sat.
//
// An eight-stage pipeline that takes one RGBA pixel per clock while req_stall is low and
// returns it adjusted by exposure, contrast, brightness, saturation and temperature; alpha
// is copied. Throughput is one pixel per cycle when the output is not stalled. No stage
// chains two multiplies, and the widest product is the 26 by 16 bit saturation term.
// Stages advance independently, so bubbles close up behind a stalled output, and req_stall
// rises only when all eight stages hold an item. Write the control registers only while
// no item is in flight.
module rgb_color_adjust_chain (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  rcac_pkg::req_data_type                    req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output rcac_pkg::rsp_data_type                    rsp_data,
   input  logic                                      csr_write_en,
   input  logic [rcac_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [rcac_pkg::CSR_DATA_WIDTH-1:0]       csr_wdata
);
   import rcac_pkg::*;

   logic [15:0]            exposure_gain_ff;
   logic [15:0]            contrast_gain_ff;
   logic signed [8:0]      brightness_offset_ff;
   logic signed [15:0]     saturation_gain_ff;
   logic signed [15:0]     temperature_shift_ff;

   logic [NUM_STAGES-1:0]  valid_ff;
   logic [NUM_STAGES-1:0]  adv;
   stage_ctl_type          ctl;
   logic [NUM_STAGES-2:0][7:0] alpha_ff;

   logic [2:0][7:0]        tone_chan;
   logic [2:0][7:0]        sat_chan;

   logic signed [16:0]     red_gain;
   logic signed [16:0]     blue_gain;
   logic signed [25:0]     red_prod_ff, red_prod_in;
   logic signed [25:0]     blue_prod_ff, blue_prod_in;
   logic [7:0]             green_t_ff;
   logic [7:0]             red_final;
   logic [7:0]             blue_final;
   rsp_data_type           rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exposure_gain_ff     <= EXPOSURE_GAIN_RESET;
         contrast_gain_ff     <= CONTRAST_GAIN_RESET;
         brightness_offset_ff <= BRIGHTNESS_OFFSET_RESET;
         saturation_gain_ff   <= SATURATION_GAIN_RESET;
         temperature_shift_ff <= TEMPERATURE_SHIFT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_EXPOSURE_GAIN: begin
               exposure_gain_ff <= csr_wdata;
            end
            CSR_CONTRAST_GAIN: begin
               contrast_gain_ff <= csr_wdata;
            end
            CSR_BRIGHTNESS_OFFSET: begin
               brightness_offset_ff <= $signed(csr_wdata[8:0]);
            end
            CSR_SATURATION_GAIN: begin
               saturation_gain_ff <= $signed(csr_wdata);
            end
            CSR_TEMPERATURE_SHIFT: begin
               temperature_shift_ff <= $signed(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      ctl.advance = adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         alpha_ff[0] <= req_data.alpha_in;
      end
      for (int k = 1; k < NUM_STAGES - 1; k++) begin
         if (adv[k]) begin
            alpha_ff[k] <= alpha_ff[k-1];
         end
      end
   end

   rcac_tone u_tone_red (
      .clock             (clock),
      .ctl               (ctl),
      .chan_in           (req_data.red_in),
      .exposure_gain     (exposure_gain_ff),
      .contrast_gain     (contrast_gain_ff),
      .brightness_offset (brightness_offset_ff),
      .chan_out          (tone_chan[0])
   );

   rcac_tone u_tone_green (
      .clock             (clock),
      .ctl               (ctl),
      .chan_in           (req_data.green_in),
      .exposure_gain     (exposure_gain_ff),
      .contrast_gain     (contrast_gain_ff),
      .brightness_offset (brightness_offset_ff),
      .chan_out          (tone_chan[1])
   );

   rcac_tone u_tone_blue (
      .clock             (clock),
      .ctl               (ctl),
      .chan_in           (req_data.blue_in),
      .exposure_gain     (exposure_gain_ff),
      .contrast_gain     (contrast_gain_ff),
      .brightness_offset (brightness_offset_ff),
      .chan_out          (tone_chan[2])
   );

   rcac_sat u_sat (
      .clock           (clock),
      .ctl             (ctl),
      .chan_in         (tone_chan),
      .saturation_gain (saturation_gain_ff),
      .chan_out        (sat_chan)
   );

   always_comb begin
      red_gain     = 17'sd4096 + 17'(temperature_shift_ff);
      blue_gain    = 17'sd4096 - 17'(temperature_shift_ff);
      red_prod_in  = 26'($signed({1'b0, sat_chan[0]})) * 26'(red_gain);
      blue_prod_in = 26'($signed({1'b0, sat_chan[2]})) * 26'(blue_gain);

      if (red_prod_ff[25]) begin
         red_final = 8'd0;
      end else if (red_prod_ff[24:20] != 5'd0) begin
         red_final = PIXEL_MAX;
      end else begin
         red_final = red_prod_ff[19:12];
      end

      if (blue_prod_ff[25]) begin
         blue_final = 8'd0;
      end else if (blue_prod_ff[24:20] != 5'd0) begin
         blue_final = PIXEL_MAX;
      end else begin
         blue_final = blue_prod_ff[19:12];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_TEMP_MUL]) begin
         red_prod_ff  <= red_prod_in;
         blue_prod_ff <= blue_prod_in;
         green_t_ff   <= sat_chan[1];
      end
      if (adv[ST_OUTPUT]) begin
         rsp_data_ff.red_out   <= red_final;
         rsp_data_ff.green_out <= green_t_ff;
         rsp_data_ff.blue_out  <= blue_final;
         rsp_data_ff.alpha_out <= alpha_ff[NUM_STAGES-2];
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign rsp_data  = rsp_data_ff;

   // The input is held back only when every stage holds an item.
   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled while the pipeline has a free stage");

   // An item taken in without one leaving adds exactly one to the pipeline occupancy.
   a_occupancy_grows : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !(rsp_valid && !rsp_stall))
      |=> ($countones(valid_ff) == $past($countones(valid_ff)) + 1))
      else $error("accepted item was lost or duplicated in the pipeline");

   // An item leaving with none behind it leaves the output empty.
   a_output_drains : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !valid_ff[NUM_STAGES-2]) |=> !rsp_valid)
      else $error("result repeated after delivery");

endmodule
